FILE: sv/bvc_pkg.sv
// Shared constants and breakpoint tables for the battery capacity lookup.
`timescale 1ns / 1ps

package bvc_pkg;

  // Input and result widths
  localparam int unsigned VoltW = 13;
  localparam int unsigned PctW  = 7;

  // Breakpoint table: 13 points, highest voltage first
  localparam int unsigned NumPoints = 13;
  localparam int unsigned SegW      = 4;

  // Offset into a segment stays below the widest span (500 mV)
  localparam int unsigned DvW    = 9;
  // Percent span of a segment (at most 10)
  localparam int unsigned SpanW  = 4;
  // Offset times percent span stays below 500 * 5 = 2500
  localparam int unsigned ProdW  = 12;
  // Scale of the reciprocal used to divide by the voltage span
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW     = 20;
  localparam int unsigned MulW       = ProdW + RecipW;
  // Quotient never exceeds the percent span
  localparam int unsigned QuotW  = 4;

  localparam longint unsigned RecipOne = 64'd1 << RecipShift;

  localparam logic [VoltW-1:0] SocMv [NumPoints] = '{
    13'd4200, 13'd4080, 13'd4000, 13'd3930, 13'd3870, 13'd3820, 13'd3790,
    13'd3770, 13'd3730, 13'd3700, 13'd3680, 13'd3500, 13'd3000
  };

  localparam logic [PctW-1:0] SocPct [NumPoints] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
    7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  // Percent span of the segment that ends at each breakpoint (top entry unused)
  localparam logic [SpanW-1:0] SpanPct [NumPoints] = '{
    4'd0, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd5, 4'd5, 4'd5, 4'd5
  };

  // Rounded-up reciprocal of each segment's voltage span, scaled by 2^RecipShift;
  // exact for every dividend below 2^ProdW since span * 2^ProdW < 2^RecipShift
  localparam logic [RecipW-1:0] SpanRecip [NumPoints] = '{
    RecipW'(0),
    RecipW'((RecipOne + 120 - 1) / 120),
    RecipW'((RecipOne + 80 - 1) / 80),
    RecipW'((RecipOne + 70 - 1) / 70),
    RecipW'((RecipOne + 60 - 1) / 60),
    RecipW'((RecipOne + 50 - 1) / 50),
    RecipW'((RecipOne + 30 - 1) / 30),
    RecipW'((RecipOne + 20 - 1) / 20),
    RecipW'((RecipOne + 40 - 1) / 40),
    RecipW'((RecipOne + 30 - 1) / 30),
    RecipW'((RecipOne + 20 - 1) / 20),
    RecipW'((RecipOne + 180 - 1) / 180),
    RecipW'((RecipOne + 500 - 1) / 500)
  };

  localparam logic [PctW-1:0] PctFull  = 7'd100;
  localparam logic [PctW-1:0] PctEmpty = 7'd0;

endpackage

FILE: sv/battery_voltage_to_capacity.sv
// Pipelined battery voltage to state-of-charge lookup with linear interpolation.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry voltage_mv_i (mV, unsigned).
//   Output channel: out_valid_o / out_stall_i carry capacity_pct_o (0..100 %).
//   A transaction moves at a rising edge where valid is high and stall is low.
// Pipeline: four register stages (segment select, span multiply, reciprocal
//   multiply, final add); a voltage accepted into the first stage passes
//   through the others in order and waits in the last until it leaves.
// Throughput: one transaction per cycle while the output is not stalled; each
//   stage is one register deep and advances whenever the stage after it is
//   empty or moving, so bubbles are squeezed out while the output is stalled.
// Stall: when out_stall_i holds a valid result, the result stays put and the
//   pipe keeps taking inputs until all four stages are full; only then is
//   in_stall_o raised. Nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits; no result is presented after reset
//   until a new voltage is accepted. The payload registers are not reset.
`timescale 1ns / 1ps

module battery_voltage_to_capacity (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bvc_pkg::VoltW-1:0]   voltage_mv_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bvc_pkg::PctW-1:0]    capacity_pct_o
);

  // Stage registers
  logic                           s1_valid_q;
  logic [bvc_pkg::PctW-1:0]       s1_base_q;
  logic [bvc_pkg::SpanW-1:0]      s1_span_q;
  logic [bvc_pkg::RecipW-1:0]     s1_recip_q;
  logic [bvc_pkg::DvW-1:0]        s1_dv_q;

  logic                           s2_valid_q;
  logic [bvc_pkg::PctW-1:0]       s2_base_q;
  logic [bvc_pkg::RecipW-1:0]     s2_recip_q;
  logic [bvc_pkg::ProdW-1:0]      s2_prod_q;

  logic                           s3_valid_q;
  logic [bvc_pkg::PctW-1:0]       s3_base_q;
  logic [bvc_pkg::MulW-1:0]       s3_mul_q;

  logic                           out_valid_q;
  logic [bvc_pkg::PctW-1:0]       out_pct_q;

  // Stage inputs
  logic [bvc_pkg::PctW-1:0]       s1_base_d;
  logic [bvc_pkg::SpanW-1:0]      s1_span_d;
  logic [bvc_pkg::RecipW-1:0]     s1_recip_d;
  logic [bvc_pkg::DvW-1:0]        s1_dv_d;
  logic [bvc_pkg::ProdW-1:0]      s2_prod_d;
  logic [bvc_pkg::MulW-1:0]       s3_mul_d;
  logic [bvc_pkg::QuotW-1:0]      s3_quot;
  logic [bvc_pkg::PctW-1:0]       out_pct_d;

  // Segment search
  logic [bvc_pkg::SegW-1:0]       seg;
  logic                           seg_found;
  logic [bvc_pkg::VoltW-1:0]      seg_diff;

  // Per-stage advance enables
  logic en_out, en_s3, en_s2, en_s1;

  // Let each stage move when its successor is empty or moving
  assign en_out = !out_valid_q || !out_stall_i;
  assign en_s3  = !s3_valid_q || en_out;
  assign en_s2  = !s2_valid_q || en_s3;
  assign en_s1  = !s1_valid_q || en_s2;

  assign in_stall_o = !en_s1;

  // Find the first breakpoint at or below the input voltage
  always_comb begin
    seg       = '0;
    seg_found = 1'b0;
    for (int k = bvc_pkg::NumPoints - 1; k >= 0; k--) begin
      if (voltage_mv_i >= bvc_pkg::SocMv[k]) begin
        seg       = bvc_pkg::SegW'(k);
        seg_found = 1'b1;
      end
    end
  end

  // Pick base percent, spans and offset; saturate above the top and below the bottom
  always_comb begin
    seg_diff   = voltage_mv_i - bvc_pkg::SocMv[seg];
    s1_base_d  = bvc_pkg::PctEmpty;
    s1_span_d  = '0;
    s1_recip_d = '0;
    s1_dv_d    = '0;
    priority if (!seg_found) begin
      s1_base_d = bvc_pkg::PctEmpty;
    end else if (seg == '0) begin
      s1_base_d = bvc_pkg::PctFull;
    end else begin
      s1_base_d  = bvc_pkg::SocPct[seg];
      s1_span_d  = bvc_pkg::SpanPct[seg];
      s1_recip_d = bvc_pkg::SpanRecip[seg];
      s1_dv_d    = seg_diff[bvc_pkg::DvW-1:0];
    end
  end

  // Scale the offset by the percent span, then by the reciprocal of the voltage span
  assign s2_prod_d = bvc_pkg::ProdW'(s1_dv_q * s1_span_q);
  assign s3_mul_d  = bvc_pkg::MulW'(s2_prod_q) * bvc_pkg::MulW'(s2_recip_q);

  // Take the quotient and add it to the base percent
  assign s3_quot   = s3_mul_q[bvc_pkg::RecipShift +: bvc_pkg::QuotW];
  assign out_pct_d = s3_base_q + bvc_pkg::PctW'(s3_quot);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1)  s1_valid_q  <= in_valid_i;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_s3)  s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      s1_base_q  <= s1_base_d;
      s1_span_q  <= s1_span_d;
      s1_recip_q <= s1_recip_d;
      s1_dv_q    <= s1_dv_d;
    end
    if (en_s2) begin
      s2_base_q  <= s1_base_q;
      s2_recip_q <= s1_recip_q;
      s2_prod_q  <= s2_prod_d;
    end
    if (en_s3) begin
      s3_base_q <= s2_base_q;
      s3_mul_q  <= s3_mul_d;
    end
    if (en_out) begin
      out_pct_q <= out_pct_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign capacity_pct_o = out_pct_q;

`ifndef SYNTHESIS
  // Result never exceeds full charge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (capacity_pct_o <= bvc_pkg::PctFull))
    else $error("capacity above 100 percent");

  // Input is held off only when every stage is full behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q && s2_valid_q && s3_valid_q))
    else $error("input stalled with room in the pipe");

  // Saturated voltages carry no interpolation offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_span_q == '0)) |-> (s1_dv_q == '0))
    else $error("offset present on a saturated voltage");

  // Interpolated quotient stays below the widest percent span of 10
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_quot < bvc_pkg::QuotW'(10)) || (s3_quot == '0))
    else $error("interpolation quotient out of range");
`endif

endmodule
